// ===== hdl/byte_ring_fifo_with_rewind_assert.svh =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_rewind_assert.svh
// Assertion macros for the byte ring FIFO; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_WITH_REWIND_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_REWIND_ASSERT_SVH

`ifndef SYNTHESIS
// Antecedent true implies consequent in the same cycle
`define BRF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent true implies consequent in the next cycle
`define BRF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BRF_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define BRF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hdl/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Types, codes and helpers used by the byte ring FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 11;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Operation codes carried in s_tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE  = 2'd0,
        FN_READ   = 2'd1,
        FN_SKIP   = 2'd2,
        FN_UNREAD = 2'd3
    } func_t;

    // Status codes carried in m_tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_REFUSED = 2'd2,
        ST_NODATA  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_BURST = 1'b1
    } state_t;

    // One result transaction
    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic               last;
        logic [COUNT_W-1:0] moved;
        logic [COUNT_W-1:0] fill;
        status_t            status;
    } result_t;

    // Clip a report value to the field range
    function automatic logic [COUNT_W-1:0] sat_report(input logic [31:0] v);
        if (v > 32'd2047) begin
            return {COUNT_W{1'b1}};
        end
        return v[COUNT_W-1:0];
    endfunction

endpackage

// ===== hdl/brf_ram.sv =====
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port: hold the last word until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/byte_ring_fifo_with_rewind.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_rewind
// Circular byte FIFO with write, clamped read burst, skip and unread.
//
//   channel | direction | tdata (low bit up)                | tuser   | tlast
//   s_      | in        | data_in[7:0] count[18:8]          | func    | -
//   m_      | out       | data_out[7:0] moved[18:8] fill... | status  | last
//
// Write, skip and unread give one result: the accept loads the result stage,
// then the move of the result into the output register reopens the input.
// A read of n bytes returns one byte per cycle while m_ is not back-pressured,
// paced by the single, registered read port of the byte store.
// Back-pressure on m_ holds the output register, then the result stage, and
// keeps s_tready low; a new item waits for an empty result stage and no burst.
// Reset clears pointers and fill level; the byte store needs no clearing.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_with_rewind_assert.svh"

module byte_ring_fifo_with_rewind #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [brf_pkg::S_TDATA_W-1:0]   s_tdata,  // data_in[7:0], count[18:8]
    input  logic [brf_pkg::FUNC_W-1:0]      s_tuser,  // func[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [brf_pkg::M_TDATA_W-1:0]   m_tdata,  // data_out[7:0], moved[18:8],
                                                      // fill_level[29:19]
    output logic                            m_tlast,  // last
    output logic [brf_pkg::STATUS_W-1:0]    m_tuser   // status[1:0]
);

    import brf_pkg::*;

    localparam int PW   = $clog2(DEPTH);
    localparam int UW   = $clog2(DEPTH + 1);
    localparam int NW   = $clog2(MAX_BURST + 1);
    localparam int CMPW = (UW > COUNT_W) ? UW : COUNT_W;
    localparam int SW   = CMPW + 1;

    state_t             state_reg, state_next;
    logic [PW-1:0]      rp_reg, rp_next;
    logic [PW-1:0]      wp_reg, wp_next;
    logic [UW-1:0]      used_reg, used_next;
    logic               pend_reg, pend_next;
    logic [NW-1:0]      remain_reg, remain_next;
    logic [COUNT_W-1:0] burst_moved_reg, burst_moved_next;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    result_t            m_reg, m_next;

    logic               ram_we, ram_re;
    logic [DATA_W-1:0]  ram_rdata;

    logic [DATA_W-1:0]  in_data;
    logic [COUNT_W-1:0] in_count;
    func_t              in_func;
    logic               accept, res_move, res_free;
    logic [CMPW-1:0]    count_w, used_w, n_skip, n_rd;
    logic [SW-1:0]      rp_skip_sum, rp_unread_sum;
    logic [PW-1:0]      rp_inc;
    result_t            res_in;
    logic               res_load;

    // Unpack the input transaction
    assign in_data  = s_tdata[DATA_W-1:0];
    assign in_count = s_tdata[DATA_W+COUNT_W-1:DATA_W];
    assign in_func  = func_t'(s_tuser);

    // Byte store
    brf_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (in_data),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    // Clamps and pointer arithmetic
    always_comb begin
        count_w = CMPW'(in_count);
        used_w  = CMPW'(used_reg);
        n_skip  = (count_w > used_w) ? used_w : count_w;
        n_rd    = (n_skip > CMPW'(MAX_BURST)) ? CMPW'(MAX_BURST) : n_skip;
        rp_skip_sum = SW'(rp_reg) + SW'(n_skip);
        if (rp_skip_sum >= SW'(DEPTH)) begin
            rp_skip_sum = rp_skip_sum - SW'(DEPTH);
        end
        rp_unread_sum = SW'(rp_reg) + SW'(DEPTH) - SW'(in_count);
        if (rp_unread_sum >= SW'(DEPTH)) begin
            rp_unread_sum = rp_unread_sum - SW'(DEPTH);
        end
        rp_inc = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
    end

    assign res_move = res_valid_reg && (!m_valid_reg || m_tready);
    assign res_free = !res_valid_reg || res_move;
    assign s_tready = (state_reg == S_IDLE) && !res_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Next state, store accesses and results
    always_comb begin
        state_next       = state_reg;
        rp_next          = rp_reg;
        wp_next          = wp_reg;
        used_next        = used_reg;
        pend_next        = pend_reg;
        remain_next      = remain_reg;
        burst_moved_next = burst_moved_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        res_load         = 1'b0;
        res_in           = '0;
        res_in.last      = 1'b1;
        res_in.status    = ST_OK;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_load = 1'b1;
                    case (in_func)
                        FN_WRITE: begin
                            if (used_reg >= UW'(DEPTH)) begin
                                res_in.status = ST_FULL;
                            end else begin
                                ram_we       = 1'b1;
                                wp_next      = (wp_reg == PW'(DEPTH - 1)) ? '0
                                                                          : wp_reg + PW'(1);
                                used_next    = used_reg + UW'(1);
                                res_in.moved = COUNT_W'(1);
                            end
                        end
                        FN_READ: begin
                            if (n_rd == '0) begin
                                res_in.status = ST_NODATA;
                            end else begin
                                // Start the burst: issue the first store read
                                res_load         = 1'b0;
                                ram_re           = 1'b1;
                                rp_next          = rp_inc;
                                used_next        = used_reg - UW'(n_rd);
                                remain_next      = NW'(n_rd - CMPW'(1));
                                burst_moved_next = COUNT_W'(n_rd);
                                pend_next        = 1'b1;
                                state_next       = S_BURST;
                            end
                        end
                        FN_SKIP: begin
                            if (n_skip == '0) begin
                                res_in.status = ST_NODATA;
                            end else begin
                                rp_next      = rp_skip_sum[PW-1:0];
                                used_next    = used_reg - UW'(n_skip);
                                res_in.moved = sat_report(32'(n_skip));
                            end
                        end
                        FN_UNREAD: begin
                            if (count_w > CMPW'(UW'(DEPTH) - used_reg)) begin
                                res_in.status = ST_REFUSED;
                            end else begin
                                rp_next      = rp_unread_sum[PW-1:0];
                                used_next    = used_reg + UW'(in_count);
                                res_in.moved = in_count;
                            end
                        end
                        default: begin
                            res_in.status = ST_NODATA;
                        end
                    endcase
                    res_in.fill = sat_report(32'(used_next));
                end
            end
            S_BURST: begin
                // Hand the fetched byte on and fetch the next one
                if (pend_reg && res_free) begin
                    res_load     = 1'b1;
                    res_in.data  = ram_rdata;
                    res_in.last  = (remain_reg == '0);
                    res_in.moved = burst_moved_reg;
                    res_in.fill  = sat_report(32'(used_reg));
                    if (remain_reg != '0) begin
                        ram_re      = 1'b1;
                        rp_next     = rp_inc;
                        remain_next = remain_reg - NW'(1);
                    end else begin
                        pend_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result stage and output register
    always_comb begin
        res_valid_next = res_valid_reg && !res_move;
        res_next       = res_reg;
        if (res_load) begin
            res_valid_next = 1'b1;
            res_next       = res_in;
        end
        m_valid_next = m_valid_reg && !m_tready;
        m_next       = m_reg;
        if (res_move) begin
            m_valid_next = 1'b1;
            m_next       = res_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            used_reg      <= used_next;
            pend_reg      <= pend_next;
            remain_reg    <= remain_next;
            res_valid_reg <= res_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        burst_moved_reg <= burst_moved_next;
        res_reg         <= res_next;
        m_reg           <= m_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - 2 * COUNT_W){1'b0}},
                       m_reg.fill, m_reg.moved, m_reg.data};
    assign m_tlast  = m_reg.last;
    assign m_tuser  = m_reg.status;

    // Checks
    `BRF_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, used_reg <= UW'(DEPTH), "fill above depth")
    `BRF_ASSERT_NOW(a_burst_pend, aclk, aresetn, state_reg == S_BURST, pend_reg, "burst w/o fetch")
    `BRF_ASSERT_NOW(a_no_wr_burst, aclk, aresetn, ram_we, state_reg == S_IDLE, "write in burst")
    `BRF_ASSERT_NOW(a_err_last, aclk, aresetn, m_valid_reg && (m_reg.status != ST_OK),
        m_reg.last && (m_reg.data == '0), "error result not single")

endmodule
